// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    `ASSERT_PROP(lbl, clk, rstn, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    `ASSERT_PROP(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

// ===== rtl/mm64a_pkg.sv =====
`timescale 1ns / 1ps

package mm64a_pkg;

    localparam logic [63:0] MUL_M      = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUL_M_LO   = MUL_M[31:0];
    localparam logic [31:0] MUL_M_HI   = MUL_M[63:32];
    localparam int unsigned SHIFT_R    = 47;
    localparam logic [3:0]  FULL_COUNT = 4'd8;

    // How the back end has to treat one word.
    typedef enum logic [1:0] {
        KIND_NONE = 2'b00,
        KIND_TAIL = 2'b01,
        KIND_FULL = 2'b10
    } word_kind_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic [63:0] word;
        word_kind_t  kind;
        logic [31:0] total;
        logic        last;
    } op_t;

    function automatic logic [63:0] xorshift(input logic [63:0] v);
        return v ^ (v >> SHIFT_R);
    endfunction

endpackage

// ===== rtl/murmur64a_string_hash.sv =====
`timescale 1ns / 1ps
// A last word with eight bytes passes the K1, K2, H and FIN multiply steps before its hash
// shows, with INIT ahead of them for a string's first word; a last tail word passes H and
// FIN, an empty one FIN only. The single multiply-by-M unit sets the rate: no new word leaves
// the queue until the current one is done, and FIN waits while the output is still full.
// Reset: synchronous active-low aresetn empties the queue, drops any pending result and
// clears the running hash so the next item starts a new string.

module murmur64a_string_hash #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic [31:0] s_total_length,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);
    import mm64a_pkg::*;

    // The front end masks each incoming item to its valid bytes and tags it as a full
    // word, a tail or an empty word; the item then waits in a short queue so the input
    // side keeps accepting while the hash core is busy with the previous one.
    op_t  push_op;
    op_t  head_op;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    mm64a_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .s_byte_count   (s_byte_count),
        .s_total_length (s_total_length),
        .s_last_word    (s_last_word),
        .queue_full     (queue_full),
        .push           (push),
        .push_op        (push_op)
    );

    mm64a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .full    (queue_full),
        .pop     (pop),
        .head_op (head_op),
        .empty   (queue_empty)
    );

    // The core runs the mix and finalization steps through one shared multiplier and
    // holds the finished hash in an output register, so a waiting result does not
    // stop the core from taking the next item of a new string.
    mm64a_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_op      (head_op),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule

// ===== rtl/mm64a_front.sv =====
`timescale 1ns / 1ps

module mm64a_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [63:0]      s_data_word,
    input  logic [3:0]       s_byte_count,
    input  logic [31:0]      s_total_length,
    input  logic             s_last_word,
    input  logic             queue_full,
    output logic             push,
    output mm64a_pkg::op_t   push_op
);
    import mm64a_pkg::*;

    logic [3:0]  count_clamped;
    logic [63:0] word_masked;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // Counts above eight act as a full word; bytes beyond the count are dropped.
    always_comb begin
        count_clamped = (s_byte_count > FULL_COUNT) ? FULL_COUNT : s_byte_count;
        for (int i = 0; i < 8; i++) begin
            word_masked[8*i +: 8] = (4'(i) < count_clamped) ? s_data_word[8*i +: 8] : 8'h00;
        end
    end

    always_comb begin
        push_op.word  = word_masked;
        push_op.total = s_total_length;
        push_op.last  = s_last_word;
        if (count_clamped == FULL_COUNT) begin
            push_op.kind = KIND_FULL;
        end else if (count_clamped == 4'd0) begin
            push_op.kind = KIND_NONE;
        end else begin
            push_op.kind = KIND_TAIL;
        end
    end

endmodule

// ===== rtl/mm64a_fifo.sv =====
`timescale 1ns / 1ps

module mm64a_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mm64a_pkg::op_t   push_op,
    output logic             full,
    input  logic             pop,
    output mm64a_pkg::op_t   head_op,
    output logic             empty
);
    import mm64a_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/mm64a_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm64a_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  mm64a_pkg::op_t   head_op,
    input  logic             queue_empty,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [63:0]      m_hash_value
);
    import mm64a_pkg::*;

    // Each multiply by M has a P state (partial products) and an S state (sum).
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_INIT_P = 11'b000_0000_0010,
        ST_INIT_S = 11'b000_0000_0100,
        ST_K1_P   = 11'b000_0000_1000,
        ST_K1_S   = 11'b000_0001_0000,
        ST_K2_P   = 11'b000_0010_0000,
        ST_K2_S   = 11'b000_0100_0000,
        ST_H_P    = 11'b000_1000_0000,
        ST_H_S    = 11'b001_0000_0000,
        ST_FIN_P  = 11'b010_0000_0000,
        ST_FIN_S  = 11'b100_0000_0000
    } core_state_t;

    core_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic [63:0] h_reg, h_next;
    logic        in_string_reg, in_string_next;
    logic [63:0] mul_a_reg, mul_a_next;
    logic [63:0] pp_ll_reg, pp_ll_next;
    logic [31:0] pp_cross_reg, pp_cross_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_hash_reg, m_hash_next;

    logic [63:0] prod;
    op_t         d_op;
    logic [63:0] d_h;
    core_state_t dsp_state;
    logic [63:0] dsp_mul_a;
    logic        dsp_store;

    // Low 64 bits of mul_a * M from three 32-bit partial products.
    assign pp_ll_next    = mul_a_reg[31:0] * MUL_M_LO;
    assign pp_cross_next = mul_a_reg[31:0] * MUL_M_HI + mul_a_reg[63:32] * MUL_M_LO;
    assign prod          = pp_ll_reg + {pp_cross_reg, 32'h0};

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    // Picks the work for an item once its starting hash is known.
    always_comb begin
        d_op      = (state_reg == ST_IDLE) ? head_op : op_reg;
        d_h       = (state_reg == ST_INIT_S) ? prod : h_reg;
        dsp_store = 1'b0;
        case (d_op.kind)
            KIND_FULL: begin
                dsp_state = ST_K1_P;
                dsp_mul_a = d_op.word;
            end
            KIND_TAIL: begin
                dsp_state = ST_H_P;
                dsp_mul_a = d_h ^ d_op.word;
            end
            default: begin
                dsp_mul_a = xorshift(d_h);
                if (d_op.last) begin
                    dsp_state = ST_FIN_P;
                end else begin
                    dsp_state = ST_IDLE;
                    dsp_store = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        h_next         = h_reg;
        in_string_next = in_string_reg;
        mul_a_next     = mul_a_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_hash_next    = m_hash_reg;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    pop     = 1'b1;
                    op_next = head_op;
                    if (!in_string_reg) begin
                        mul_a_next = {32'h0, head_op.total};
                        state_next = ST_INIT_P;
                    end else begin
                        mul_a_next = dsp_mul_a;
                        state_next = dsp_state;
                        if (dsp_store) begin
                            in_string_next = 1'b1;
                        end
                    end
                end
            end
            ST_INIT_P: begin
                state_next = ST_INIT_S;
            end
            ST_INIT_S: begin
                h_next     = prod;
                mul_a_next = dsp_mul_a;
                state_next = dsp_state;
                if (dsp_store) begin
                    in_string_next = 1'b1;
                end
            end
            ST_K1_P: begin
                state_next = ST_K1_S;
            end
            ST_K1_S: begin
                mul_a_next = xorshift(prod);
                state_next = ST_K2_P;
            end
            ST_K2_P: begin
                state_next = ST_K2_S;
            end
            ST_K2_S: begin
                mul_a_next = h_reg ^ prod;
                state_next = ST_H_P;
            end
            ST_H_P: begin
                state_next = ST_H_S;
            end
            ST_H_S: begin
                if (op_reg.last) begin
                    mul_a_next = xorshift(prod);
                    state_next = ST_FIN_P;
                end else begin
                    h_next         = prod;
                    in_string_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FIN_P: begin
                state_next = ST_FIN_S;
            end
            ST_FIN_S: begin
                // Wait here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_hash_next    = xorshift(prod);
                    h_next         = '0;
                    in_string_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            h_reg         <= '0;
            in_string_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            in_string_reg <= in_string_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        mul_a_reg    <= mul_a_next;
        pp_ll_reg    <= pp_ll_next;
        pp_cross_reg <= pp_cross_next;
        m_hash_reg   <= m_hash_next;
    end

    `ASSERT_IMPL(a_idle_hash_zero, aclk, aresetn, (state_reg == ST_IDLE) && !in_string_reg, h_reg == 64'h0, "hash not cleared between strings")
    `ASSERT_IMPL(a_result_from_fin, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_FIN_S), "result raised outside finalization")
    `ASSERT_NEXT(a_fin_holds, aclk, aresetn, (state_reg == ST_FIN_S) && m_valid_reg && !m_ready, state_reg == ST_FIN_S, "finalization left while output busy")

endmodule
